>>> design/pkw2d_pkg.sv
// ----------------------------------------------------------------------------
// pkw2d_pkg
// Shared types and constants of the 2-D product kernel weight unit.
// ----------------------------------------------------------------------------
package pkw2d_pkg;

  typedef enum logic [1:0] {
    MODE_GAUSS   = 2'd0,
    MODE_EPAN    = 2'd1,
    MODE_UNIFORM = 2'd2,
    MODE_UNSUP   = 2'd3
  } kernel_mode_t;

  localparam int CFG_DATA_W = 32;

  typedef logic [1:0]            cfg_index_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_index_t CFG_KERNEL_MODE     = 2'd0;
  localparam cfg_index_t CFG_INV_BANDWIDTH_X = 2'd1;
  localparam cfg_index_t CFG_INV_BANDWIDTH_Y = 2'd2;

  localparam cfg_data_t   BW_RESET       = 32'h0001_0000;
  localparam logic [20:0] T_SAT          = 21'h10_0000;   // 16.0 in Q16.16
  localparam logic [16:0] T_ONE          = 17'h1_0000;    // 1.0 in Q16.16
  localparam logic [15:0] UNIFORM_WEIGHT = 16'd16384;     // 0.25 in Q0.16
  localparam logic [63:0] INV_TWO_PI     = 64'd10430;     // 1/(2*pi) in Q0.16
  localparam logic [6:0]  EPAN_COEF      = 7'd81;         // 81/256 before the shift

endpackage

>>> design/product_kernel_weight_2d_unit.sv
// ----------------------------------------------------------------------------
// product_kernel_weight_2d_unit
// Product kernel weight of one sample point against one centre, gaussian,
// epanechnikov or uniform, as an eight-stage pipeline.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle, set by the fully pipelined datapath
// with no shared unit. The receiver cannot stall, so no backpressure exists;
// busy is high only during reset.
// Reset (synchronous, active low) clears all valid bits and loads the
// configuration defaults: gaussian mode and both inverse bandwidths at 1.0.
// ----------------------------------------------------------------------------
module product_kernel_weight_2d_unit #(
  parameter int EXP_TABLE_DEPTH = 256,
  parameter int COORD_WIDTH     = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_sample_x,
  input  logic signed [COORD_WIDTH-1:0] in_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_sample_y,
  input  logic signed [COORD_WIDTH-1:0] in_center_y,
  input  logic                          cfg_we,
  input  pkw2d_pkg::cfg_index_t         cfg_index,
  input  pkw2d_pkg::cfg_data_t          cfg_data,
  output logic                          out_valid,
  output logic [15:0]                   out_weight,
  output logic                          out_mode_error
);
  import pkw2d_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int PPW   = (W + 17 > 40) ? W + 17 : 40;
  localparam int IW    = $clog2(EXP_TABLE_DEPTH);
  localparam int PRODW = 20 + $clog2(EXP_TABLE_DEPTH + 1);

  // Exponential step p = exp(-16/depth) in Q0.32 from a 20-term series.
  localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
  localparam logic [63:0] EXP_X   = (64'd16 << 32) / 64'(EXP_TABLE_DEPTH);
  localparam logic [63:0] TM1  = ((ONE_Q32 * EXP_X) >> 32) / 64'd1;
  localparam logic [63:0] TM2  = ((TM1  * EXP_X) >> 32) / 64'd2;
  localparam logic [63:0] TM3  = ((TM2  * EXP_X) >> 32) / 64'd3;
  localparam logic [63:0] TM4  = ((TM3  * EXP_X) >> 32) / 64'd4;
  localparam logic [63:0] TM5  = ((TM4  * EXP_X) >> 32) / 64'd5;
  localparam logic [63:0] TM6  = ((TM5  * EXP_X) >> 32) / 64'd6;
  localparam logic [63:0] TM7  = ((TM6  * EXP_X) >> 32) / 64'd7;
  localparam logic [63:0] TM8  = ((TM7  * EXP_X) >> 32) / 64'd8;
  localparam logic [63:0] TM9  = ((TM8  * EXP_X) >> 32) / 64'd9;
  localparam logic [63:0] TM10 = ((TM9  * EXP_X) >> 32) / 64'd10;
  localparam logic [63:0] TM11 = ((TM10 * EXP_X) >> 32) / 64'd11;
  localparam logic [63:0] TM12 = ((TM11 * EXP_X) >> 32) / 64'd12;
  localparam logic [63:0] TM13 = ((TM12 * EXP_X) >> 32) / 64'd13;
  localparam logic [63:0] TM14 = ((TM13 * EXP_X) >> 32) / 64'd14;
  localparam logic [63:0] TM15 = ((TM14 * EXP_X) >> 32) / 64'd15;
  localparam logic [63:0] TM16 = ((TM15 * EXP_X) >> 32) / 64'd16;
  localparam logic [63:0] TM17 = ((TM16 * EXP_X) >> 32) / 64'd17;
  localparam logic [63:0] TM18 = ((TM17 * EXP_X) >> 32) / 64'd18;
  localparam logic [63:0] TM19 = ((TM18 * EXP_X) >> 32) / 64'd19;
  localparam logic [63:0] TM20 = ((TM19 * EXP_X) >> 32) / 64'd20;
  localparam logic [63:0] EXP_POS = ONE_Q32 + TM2 + TM4 + TM6 + TM8 + TM10
                                    + TM12 + TM14 + TM16 + TM18 + TM20;
  localparam logic [63:0] EXP_NEG = TM1 + TM3 + TM5 + TM7 + TM9 + TM11
                                    + TM13 + TM15 + TM17 + TM19;
  localparam logic [63:0] EXP_P   = EXP_POS - EXP_NEG;

  function automatic logic [EXP_TABLE_DEPTH*16-1:0] build_exp_tab();
    logic [EXP_TABLE_DEPTH*16-1:0] tab;
    logic [63:0]                   cur;
    logic [63:0]                   ent;
    tab = '0;
    cur = ONE_Q32;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      ent = (cur * INV_TWO_PI + (64'd1 << 31)) >> 32;
      tab[k*16 +: 16] = ent[15:0];
      cur = (cur * EXP_P + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam logic [EXP_TABLE_DEPTH*16-1:0] EXP_TAB = build_exp_tab();

  function automatic logic [W-1:0] abs_diff(logic [W-1:0] a, logic [W-1:0] b);
    logic [W:0] ab;
    logic [W:0] ba;
    ab = {a[W-1], a} - {b[W-1], b};
    ba = {b[W-1], b} - {a[W-1], a};
    return ab[W] ? ba[W-1:0] : ab[W-1:0];
  endfunction

  // Configuration registers.
  kernel_mode_t mode_r;
  cfg_data_t    inv_bw_x_r;
  cfg_data_t    inv_bw_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_GAUSS;
      inv_bw_x_r <= BW_RESET;
      inv_bw_y_r <= BW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KERNEL_MODE:     mode_r     <= kernel_mode_t'(cfg_data[1:0]);
        CFG_INV_BANDWIDTH_X: inv_bw_x_r <= cfg_data;
        CFG_INV_BANDWIDTH_Y: inv_bw_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic accept;
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // Valid bits travelling with the data.
  logic [7:1] vld_r;
  logic       out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[6:1], accept};
      out_valid_r <= vld_r[7];
    end
  end

  // Stage 1: distances and effective inverse bandwidths.
  logic [W-1:0]  p1_dx_r, p1_dy_r;
  logic [33:0]   p1_bx_r, p1_by_r;
  kernel_mode_t  p1_mode_r;
  logic [33:0]   bx_nxt, by_nxt;

  always_comb begin
    // Gaussian mode reads the bandwidth as three standard deviations.
    if (mode_r == MODE_GAUSS) begin
      bx_nxt = {2'b00, inv_bw_x_r} + {1'b0, inv_bw_x_r, 1'b0};
      by_nxt = {2'b00, inv_bw_y_r} + {1'b0, inv_bw_y_r, 1'b0};
    end else begin
      bx_nxt = {2'b00, inv_bw_x_r};
      by_nxt = {2'b00, inv_bw_y_r};
    end
  end

  // Stage 2: partial products on 17-bit halves of the bandwidth.
  logic [PPW-1:0] p2_xl_r, p2_xh_r, p2_yl_r, p2_yh_r;
  kernel_mode_t   p2_mode_r;

  // Stage 3: scaled distances, saturated at 16.0.
  logic [20:0]    p3_tx_r, p3_ty_r;
  kernel_mode_t   p3_mode_r;
  logic [20:0]    tx_nxt, ty_nxt;

  function automatic logic [20:0] sat_dist(logic [PPW-1:0] lo, logic [PPW-1:0] hi);
    logic [36:0] sum;
    logic        sat;
    sat = (|hi[PPW-1:19]) | (|lo[PPW-1:36]);
    sum = {hi[18:0], 17'b0} + {1'b0, lo[35:0]};
    return (sat || sum[36:16] > T_SAT) ? T_SAT : sum[36:16];
  endfunction

  assign tx_nxt = sat_dist(p2_xl_r, p2_xh_r);
  assign ty_nxt = sat_dist(p2_yl_r, p2_yh_r);

  // Stage 4: squares and the unit square test.
  logic [41:0]    sqx_prod, sqy_prod;
  logic [40:0]    p4_sqx_r, p4_sqy_r;
  logic           p4_sup_r;
  kernel_mode_t   p4_mode_r;

  assign sqx_prod = 42'(p3_tx_r) * 42'(p3_tx_r);
  assign sqy_prod = 42'(p3_ty_r) * 42'(p3_ty_r);

  // Stage 5: table index and epanechnikov factors.
  logic [41:0]      sumsq;
  logic [PRODW-1:0] idx_prod;
  logic [IW-1:0]    p5_idx_r;
  logic             p5_in_range_r;
  logic [16:0]      p5_ax_r, p5_ay_r;
  logic             p5_sup_r;
  kernel_mode_t     p5_mode_r;

  assign sumsq    = {1'b0, p4_sqx_r} + {1'b0, p4_sqy_r};
  assign idx_prod = PRODW'(sumsq[36:17]) * PRODW'(EXP_TABLE_DEPTH);

  // Stage 6: table read and product of the factors.
  logic [33:0]    axy_prod;
  logic [15:0]    p6_gw_r;
  logic [16:0]    p6_s_r;
  logic           p6_sup_r;
  kernel_mode_t   p6_mode_r;

  assign axy_prod = 34'(p5_ax_r) * 34'(p5_ay_r);

  // Stage 7: square of the factor product.
  logic [33:0]    ss_prod;
  logic [32:0]    p7_ss_r;
  logic [15:0]    p7_gw_r;
  logic           p7_sup_r;
  kernel_mode_t   p7_mode_r;

  assign ss_prod = 34'(p6_s_r) * 34'(p6_s_r);

  // Output stage.
  logic [39:0]    epan_prod;
  logic [15:0]    weight_nxt;
  logic           err_nxt;
  logic [15:0]    out_weight_r;
  logic           out_mode_error_r;

  assign epan_prod = 40'(p7_ss_r) * 40'(EPAN_COEF);

  always_comb begin
    weight_nxt = '0;
    err_nxt    = 1'b0;
    unique case (p7_mode_r)
      MODE_GAUSS:   weight_nxt = p7_gw_r;
      MODE_EPAN:    weight_nxt = p7_sup_r ? epan_prod[39:24] : 16'd0;
      MODE_UNIFORM: weight_nxt = p7_sup_r ? UNIFORM_WEIGHT : 16'd0;
      MODE_UNSUP:   err_nxt    = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    p1_dx_r   <= abs_diff(in_sample_x, in_center_x);
    p1_dy_r   <= abs_diff(in_sample_y, in_center_y);
    p1_bx_r   <= bx_nxt;
    p1_by_r   <= by_nxt;
    p1_mode_r <= mode_r;

    p2_xl_r   <= PPW'(p1_dx_r) * PPW'(p1_bx_r[16:0]);
    p2_xh_r   <= PPW'(p1_dx_r) * PPW'(p1_bx_r[33:17]);
    p2_yl_r   <= PPW'(p1_dy_r) * PPW'(p1_by_r[16:0]);
    p2_yh_r   <= PPW'(p1_dy_r) * PPW'(p1_by_r[33:17]);
    p2_mode_r <= p1_mode_r;

    p3_tx_r   <= tx_nxt;
    p3_ty_r   <= ty_nxt;
    p3_mode_r <= p2_mode_r;

    p4_sqx_r  <= sqx_prod[40:0];
    p4_sqy_r  <= sqy_prod[40:0];
    p4_sup_r  <= (p3_tx_r <= 21'(T_ONE)) && (p3_ty_r <= 21'(T_ONE));
    p4_mode_r <= p3_mode_r;

    // The table covers half the squared radius below 16.0 only.
    p5_idx_r      <= idx_prod[20 +: IW];
    p5_in_range_r <= (sumsq[41:37] == 5'd0);
    p5_ax_r       <= T_ONE - p4_sqx_r[32:16];
    p5_ay_r       <= T_ONE - p4_sqy_r[32:16];
    p5_sup_r      <= p4_sup_r;
    p5_mode_r     <= p4_mode_r;

    p6_gw_r   <= p5_in_range_r ? EXP_TAB[p5_idx_r*16 +: 16] : 16'd0;
    p6_s_r    <= axy_prod[32:16];
    p6_sup_r  <= p5_sup_r;
    p6_mode_r <= p5_mode_r;

    p7_ss_r   <= ss_prod[32:0];
    p7_gw_r   <= p6_gw_r;
    p7_sup_r  <= p6_sup_r;
    p7_mode_r <= p6_mode_r;

    out_weight_r     <= weight_nxt;
    out_mode_error_r <= err_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_weight     = out_weight_r;
  assign out_mode_error = out_mode_error_r;

  // Every accepted transaction leaves the pipeline as a result strobe.
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##8 out_valid)
    else $error("accepted transaction did not produce a result");

  // No result appears without a matching accepted transaction.
  a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 8))
    else $error("result strobe without a matching transaction");

  // An unsupported mode always gives a zero weight.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_mode_error) |-> (out_weight == 16'd0))
    else $error("non-zero weight reported with a mode error");

endmodule

>>> tb/sv/product_kernel_weight_2d_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// product_kernel_weight_2d_unit_tb
// Self-checking bench for the 2-D product kernel weight unit. A bit-accurate
// predictor computes the weight and mode error of every accepted transaction
// under the current register settings, and each result strobe is checked
// against the oldest prediction. A directed part covers the support edges,
// saturation and every kernel mode; random phases then vary the registers,
// the distances relative to the bandwidths and the input idle pattern.
// ----------------------------------------------------------------------------
module product_kernel_weight_2d_unit_tb;
  import pkw2d_pkg::*;

  localparam int EXP_DEPTH = 256;
  localparam int CLK_HALF = 5;
  localparam int NUM_PHASES = 16;
  localparam int PHASE_ITEMS = 125;
  localparam int DRAIN_CYCLES = 12;
  localparam cfg_index_t CFG_UNUSED_INDEX = 2'd3;
  localparam bit [63:0] T_LIMIT = 64'(T_SAT);
  localparam bit [31:0] COORD_MIN = 32'h8000_0000;
  localparam bit [31:0] COORD_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    bit [31:0] sample_x;
    bit [31:0] center_x;
    bit [31:0] sample_y;
    bit [31:0] center_y;
  } coord_set_t;

  typedef struct packed {
    bit [15:0] weight;
    bit        mode_error;
  } weight_result_t;

  class kernel_weight_scoreboard;
    kernel_mode_t   mode;
    bit [31:0]      bw_x;
    bit [31:0]      bw_y;
    bit [15:0]      exp_lut[EXP_DEPTH];
    weight_result_t expected_weights[$];
    int             failures;

    function new();
      bit [63:0] step, term, pos, neg, ratio, power;
      mode = MODE_GAUSS;
      bw_x = BW_RESET;
      bw_y = BW_RESET;
      failures = 0;
      // Powers of exp(-16/depth) in Q0.32, the ratio from a 20-term series.
      step = (64'd16 << 32) / EXP_DEPTH;
      term = 64'd1 << 32;
      pos = 64'd1 << 32;
      neg = 0;
      for (int k = 1; k <= 20; k++) begin
        term = ((term * step) >> 32) / k;
        if (k % 2 == 1) neg += term;
        else pos += term;
      end
      ratio = pos - neg;
      power = 64'd1 << 32;
      for (int k = 0; k < EXP_DEPTH; k++) begin
        exp_lut[k] = 16'((power * INV_TWO_PI + (64'd1 << 31)) >> 32);
        power = (power * ratio + (64'd1 << 31)) >> 32;
      end
    endfunction

    function void set_reg(cfg_index_t idx, cfg_data_t data);
      case (idx)
        CFG_KERNEL_MODE:     mode = kernel_mode_t'(data[1:0]);
        CFG_INV_BANDWIDTH_X: bw_x = data;
        CFG_INV_BANDWIDTH_Y: bw_y = data;
        default: ;
      endcase
    endfunction

    function bit [63:0] coord_gap(bit [31:0] a, bit [31:0] b);
      bit [63:0] oa, ob;
      oa = 64'(a ^ COORD_MIN);
      ob = 64'(b ^ COORD_MIN);
      return (oa >= ob) ? oa - ob : ob - oa;
    endfunction

    function bit [63:0] scaled_dist(bit [63:0] d, bit [63:0] b);
      bit [63:0] hi, lo, t;
      hi = d >> 16;
      lo = d & 64'hFFFF;
      if (hi != 0 && b > T_LIMIT / hi) return T_LIMIT;
      t = hi * b + ((lo * b) >> 16);
      return (t > T_LIMIT) ? T_LIMIT : t;
    endfunction

    function void note_item(coord_set_t c);
      bit [63:0] bx, by, t1, t2, u, idx, a1, a2, s, w;
      weight_result_t r;
      bx = 64'(bw_x);
      by = 64'(bw_y);
      if (mode == MODE_GAUSS) begin
        bx *= 3;
        by *= 3;
      end
      t1 = scaled_dist(coord_gap(c.sample_x, c.center_x), bx);
      t2 = scaled_dist(coord_gap(c.sample_y, c.center_y), by);
      w = 0;
      r.mode_error = 1'b0;
      case (mode)
        MODE_GAUSS: begin
          u = (t1 * t1 + t2 * t2) >> 17;
          idx = (u * EXP_DEPTH) >> 20;
          if (idx < EXP_DEPTH) w = 64'(exp_lut[idx]);
        end
        MODE_EPAN: begin
          if (t1 <= 64'(T_ONE) && t2 <= 64'(T_ONE)) begin
            a1 = 64'(T_ONE) - ((t1 * t1) >> 16);
            a2 = 64'(T_ONE) - ((t2 * t2) >> 16);
            s = (a1 * a2) >> 16;
            w = (s * s * EPAN_COEF) >> 24;
          end
        end
        MODE_UNIFORM: begin
          if (t1 <= 64'(T_ONE) && t2 <= 64'(T_ONE)) w = 64'(UNIFORM_WEIGHT);
        end
        default: r.mode_error = 1'b1;
      endcase
      r.weight = w[15:0];
      expected_weights.push_back(r);
    endfunction

    function void check_result(bit [15:0] weight, bit mode_error);
      weight_result_t e;
      if (expected_weights.size() == 0) begin
        $error("result with no transaction outstanding: weight %0d mode_error %0b",
               weight, mode_error);
        failures++;
        return;
      end
      e = expected_weights.pop_front();
      if (weight !== e.weight) begin
        $error("weight: expected %0d, actual %0d", e.weight, weight);
        failures++;
      end
      if (mode_error !== e.mode_error) begin
        $error("mode_error: expected %0b, actual %0b", e.mode_error, mode_error);
        failures++;
      end
    endfunction

    function int pending();
      return expected_weights.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [31:0]      in_sample_x;
  logic signed [31:0]      in_center_x;
  logic signed [31:0]      in_sample_y;
  logic signed [31:0]      in_center_y;
  logic                    cfg_we;
  cfg_index_t              cfg_index;
  cfg_data_t               cfg_data;
  logic                    out_valid;
  logic [15:0]             out_weight;
  logic                    out_mode_error;

  kernel_weight_scoreboard sb = new();

  product_kernel_weight_2d_unit #(
    .EXP_TABLE_DEPTH(EXP_DEPTH),
    .COORD_WIDTH(32)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_sample_x(in_sample_x),
    .in_center_x(in_center_x),
    .in_sample_y(in_sample_y),
    .in_center_y(in_center_y),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_weight(out_weight),
    .out_mode_error(out_mode_error)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_weight, out_mode_error);
  end

  task automatic write_reg(input cfg_index_t idx, input cfg_data_t data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mode values carry random upper bits now and then; only the low two count.
  task automatic write_mode(input kernel_mode_t m);
    cfg_data_t data;
    data = ($urandom_range(1) == 1) ? ($urandom & 32'hFFFF_FFFC) : 32'd0;
    write_reg(CFG_KERNEL_MODE, data | cfg_data_t'(m));
  endtask

  task automatic send_pair(input coord_set_t c);
    @(negedge clk);
    start = 1'b1;
    in_sample_x = c.sample_x;
    in_center_x = c.center_x;
    in_sample_y = c.sample_y;
    in_center_y = c.center_y;
    do @(posedge clk); while (busy);
    sb.note_item(c);
  endtask

  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      start = 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic bit [31:0] pick_bandwidth();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return BW_RESET;
      4: return $urandom;
      default: return $urandom_range(32'h0000_1000, 32'h0010_0000);
    endcase
  endfunction

  // Places the sample at a chosen scaled distance from the centre, so that
  // most transactions land inside or near the kernel support.
  function automatic bit [31:0] near_sample(bit [31:0] centre, bit [31:0] bw);
    bit [63:0] eff_b, tgt, d;
    longint c, s;
    eff_b = 64'(bw);
    if (sb.mode == MODE_GAUSS) begin
      eff_b *= 3;
      tgt = 64'($urandom_range(0, 6 * 65536 + 32768));
    end else begin
      case ($urandom_range(9))
        0: tgt = 64'(T_ONE);
        1: tgt = 64'(T_ONE) + $urandom_range(1, 3);
        default: tgt = 64'($urandom_range(0, 81920));
      endcase
    end
    if (eff_b == 0) return $urandom;
    d = (tgt << 16) / eff_b + $urandom_range(1);
    c = longint'(signed'(centre));
    s = ($urandom_range(1) == 1) ? c + longint'(d) : c - longint'(d);
    if (s > 2147483647 || s < -2147483648)
      s = (s > c) ? c - longint'(d) : c + longint'(d);
    if (s > 2147483647) s = 2147483647;
    if (s < -2147483648) s = -2147483648;
    return s[31:0];
  endfunction

  function automatic bit [31:0] edge_coord();
    case ($urandom_range(4))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return 32'd0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic coord_set_t random_pair();
    coord_set_t c;
    int kind;
    kind = $urandom_range(99);
    if (kind < 75) begin
      c.center_x = $urandom;
      c.center_y = $urandom;
      c.sample_x = near_sample(c.center_x, sb.bw_x);
      c.sample_y = near_sample(c.center_y, sb.bw_y);
    end else if (kind < 90) begin
      c = {$urandom, $urandom, $urandom, $urandom};
    end else begin
      c = {edge_coord(), edge_coord(), edge_coord(), edge_coord()};
    end
    return c;
  endfunction

  initial begin
    int idle_pct;
    rst_n = 1'b0;
    start = 1'b0;
    in_sample_x = '0;
    in_center_x = '0;
    in_sample_y = '0;
    in_center_y = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_KERNEL_MODE;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: gaussian, unit bandwidths. Peak, saturation both ways,
    // and the two sides of the end of the exponential table.
    send_pair('{0, 0, 0, 0});
    send_pair('{COORD_MAX, COORD_MIN, 0, 0});
    send_pair('{COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN});
    send_pair('{123575, 0, 0, 0});
    send_pair('{0, 123576, 0, 0});
    send_pair('{87381, 0, -87381, 0});
    wait_drained();

    write_mode(MODE_EPAN);
    send_pair('{0, 0, 0, 0});
    send_pair('{65536, 0, 0, 0});
    send_pair('{0, 0, -1, 65534});
    send_pair('{65537, 0, 0, 0});
    wait_drained();

    write_mode(MODE_UNIFORM);
    send_pair('{5, 5, 7, 7});
    send_pair('{65536, 0, 0, -65536});
    send_pair('{0, 0, 65537, 0});
    wait_drained();

    // A zero inverse bandwidth collapses that axis to the centre.
    write_reg(CFG_INV_BANDWIDTH_X, 32'd0);
    send_pair('{COORD_MAX, COORD_MIN, 100, 100});
    wait_drained();

    write_mode(MODE_UNSUP);
    send_pair('{0, 0, 0, 0});
    send_pair('{$urandom, $urandom, $urandom, $urandom});
    wait_drained();

    // Writes to the unused index must leave the settings alone.
    write_reg(CFG_UNUSED_INDEX, $urandom);
    write_mode(MODE_GAUSS);
    write_reg(CFG_INV_BANDWIDTH_X, 32'hFFFF_FFFF);
    write_reg(CFG_INV_BANDWIDTH_Y, 32'hFFFF_FFFF);
    send_pair('{1, 0, 0, 0});
    send_pair('{0, 0, 0, 0});
    wait_drained();

    write_reg(CFG_INV_BANDWIDTH_X, 32'd1);
    write_reg(CFG_INV_BANDWIDTH_Y, 32'd1);
    send_pair('{COORD_MAX, 0, 0, COORD_MIN});
    send_pair('{32'h0040_0000, 0, 0, 0});
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 86;
        2: idle_pct = 29;
        default: idle_pct = $urandom_range(50);
      endcase
      if ($urandom_range(3) == 0) write_reg(CFG_UNUSED_INDEX, $urandom);
      write_mode(kernel_mode_t'(ph < 4 ? ph : $urandom_range(3)));
      write_reg(CFG_INV_BANDWIDTH_X, pick_bandwidth());
      write_reg(CFG_INV_BANDWIDTH_Y, pick_bandwidth());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        idle_gap(idle_pct);
        send_pair(random_pair());
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
